// ----- rtl/mkde_pkg.sv -----
// ============================================================================
// mkde_pkg: shared types and constants for the key debouncer
// Holds the item types of both channels, the configuration register
// indexes and their reset values, and the per-key phase encoding.
// ============================================================================
package mkde_pkg;

    localparam int KEY_COUNT_DEF = 10;
    localparam int TICK_BITS_DEF = 32;

    localparam int LEVEL_W    = 10;
    localparam int TICK_IN_W  = 32;
    localparam int KEY_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEBOUNCE_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;

    localparam logic                  DOWN_LEVEL_RESET = 1'b0;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 16'd20;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_DEBOUNCE = 3'b010,
        PH_DOWN     = 3'b100
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0]   key_levels;
        logic [TICK_IN_W-1:0] now_tick;
    } t_scan_item;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_index;
        logic                 pressed;
        logic                 last_of_scan;
    } t_key_event;

endpackage

// ----- rtl/mkde_scan.sv -----
// ============================================================================
// mkde_scan: scan register and per-key debounce state
// Holds one accepted scan, runs every key's phase machine on it in one
// pass and hands the resulting press and release masks to the emitter.
// ============================================================================
module mkde_scan
    import mkde_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_scan_item            i_in_item,
    input  logic                  i_down_level,
    input  logic [DEBOUNCE_W-1:0] i_debounce_ticks,
    output logic                  o_ev_valid,
    input  logic                  i_ev_ready,
    output logic [KEY_COUNT-1:0]  o_ev_mask,
    output logic [KEY_COUNT-1:0]  o_ev_press
);

    localparam int CMP_W = (TICK_BITS > DEBOUNCE_W) ? TICK_BITS : DEBOUNCE_W;

    logic                 r_scan_valid;
    t_scan_item           r_scan;
    logic                 accept;
    logic                 take;
    logic [TICK_BITS-1:0] now_t;
    logic [CMP_W-1:0]     limit;

    assign o_in_stall = r_scan_valid && !i_ev_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign take       = r_scan_valid && i_ev_ready;
    assign o_ev_valid = r_scan_valid;
    assign now_t      = TICK_BITS'(r_scan.now_tick);
    assign limit      = CMP_W'(i_debounce_ticks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_valid <= 1'b0;
        end else if (accept) begin
            r_scan_valid <= 1'b1;
        end else if (i_ev_ready) begin
            r_scan_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scan <= i_in_item;
        end
    end

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        logic                 lvl;
        logic                 down;
        logic                 late;
        logic                 start_wr;
        logic [TICK_BITS-1:0] elapsed;
        t_phase               r_phase;
        t_phase               n_phase;
        logic [TICK_BITS-1:0] r_start;

        if (k < LEVEL_W) begin : g_lvl
            assign lvl = r_scan.key_levels[k];
        end else begin : g_nolvl
            assign lvl = 1'b0;
        end

        assign down    = (lvl == i_down_level);
        assign elapsed = now_t - r_start;
        assign late    = CMP_W'(elapsed) > limit;

        always_comb begin
            n_phase          = r_phase;
            start_wr         = 1'b0;
            o_ev_mask[k]     = 1'b0;
            o_ev_press[k]    = 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (down) begin
                        n_phase  = PH_DEBOUNCE;
                        start_wr = 1'b1;
                    end
                end
                PH_DEBOUNCE: begin
                    if (!down) begin
                        n_phase = PH_IDLE;
                    end else if (late) begin
                        n_phase       = PH_DOWN;
                        o_ev_mask[k]  = 1'b1;
                        o_ev_press[k] = 1'b1;
                    end
                end
                PH_DOWN: begin
                    if (!down) begin
                        n_phase      = PH_IDLE;
                        o_ev_mask[k] = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_phase <= PH_IDLE;
            end else if (take) begin
                r_phase <= n_phase;
            end
        end

        always_ff @(posedge i_clk) begin
            if (take && start_wr) begin
                r_start <= now_t;
            end
        end
    end

endmodule

// ----- rtl/mkde_emit.sv -----
// ============================================================================
// mkde_emit: event buffer and output register
// Keeps the events of one scan as a mask and sends them out one per cycle
// while not stalled, in ascending key order, flagging the final one of the scan.
// ============================================================================
module mkde_emit
    import mkde_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ev_valid,
    output logic                 o_ev_ready,
    input  logic [KEY_COUNT-1:0] i_ev_mask,
    input  logic [KEY_COUNT-1:0] i_ev_press,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_key_event           o_out_item
);

    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [KEY_COUNT-1:0] r_ev_mask;
    logic [KEY_COUNT-1:0] r_ev_press;
    logic                 r_out_valid;
    t_key_event           r_out;
    logic [KEY_COUNT-1:0] low_bit;
    logic [KEY_COUNT-1:0] rest;
    logic [KEY_COUNT-1:0] kept;
    logic [KEY_W-1:0]     idx;
    logic                 pop;

    assign low_bit    = r_ev_mask & (~r_ev_mask + KEY_COUNT'(1'b1));
    assign rest       = r_ev_mask & ~low_bit;
    assign pop        = (|r_ev_mask) && (!r_out_valid || !i_out_stall);
    assign kept       = pop ? rest : r_ev_mask;
    assign o_ev_ready = (kept == '0);

    always_comb begin
        idx = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (r_ev_mask[k]) begin
                idx = KEY_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_mask <= '0;
        end else if (i_ev_valid && o_ev_ready) begin
            r_ev_mask <= i_ev_mask;
        end else begin
            r_ev_mask <= kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ev_valid && o_ev_ready) begin
            r_ev_press <= i_ev_press;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.key_index    <= KEY_IDX_W'(idx);
            r_out.pressed      <= |(low_bit & r_ev_press);
            r_out.last_of_scan <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/multi_key_debounce_events.sv -----
// ============================================================================
// multi_key_debounce_events: multi-key debouncer with press/release events
// Each input item is one scan of all key levels with a timer tick. Every
// key is debounced against the tick, and confirmed presses and releases
// come out as event items in ascending key order.
//
// Input channel: i_in_valid / o_in_stall carry one scan item. Output
// channel: o_out_valid / i_out_stall carry one event item; the last event
// of a scan has last_of_scan set, and a scan without events gives none.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// the port is always ready, and the user must see that it is written only
// while the block is idle; the block itself does not enforce this.
// A scan passes through the scan register, event buffer and output register.
// A scan with events holds the buffer until its last event leaves, which sets
// the rate; scans without events flow at one per cycle while it is empty.
// Reset: synchronous, active low; all keys return to idle, down_level to 0
// and debounce_ticks to 20. While the output is stalled the event item
// holds, the buffer keeps the remaining events, and one further scan waits
// in the scan register before o_in_stall rises.
// ============================================================================
module multi_key_debounce_events
    import mkde_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_scan_item            i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_key_event            o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                  r_down_level;
    logic [DEBOUNCE_W-1:0] r_debounce_ticks;
    logic                  ev_valid;
    logic                  ev_ready;
    logic [KEY_COUNT-1:0]  ev_mask;
    logic [KEY_COUNT-1:0]  ev_press;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_level     <= DOWN_LEVEL_RESET;
            r_debounce_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DOWN_LEVEL: r_down_level     <= i_cfg_data[0];
                CFG_DEBOUNCE:   r_debounce_ticks <= DEBOUNCE_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    mkde_scan #(
        .KEY_COUNT (KEY_COUNT),
        .TICK_BITS (TICK_BITS)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_item        (i_in_item),
        .i_down_level     (r_down_level),
        .i_debounce_ticks (r_debounce_ticks),
        .o_ev_valid       (ev_valid),
        .i_ev_ready       (ev_ready),
        .o_ev_mask        (ev_mask),
        .o_ev_press       (ev_press)
    );

    mkde_emit #(
        .KEY_COUNT (KEY_COUNT)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (ev_valid),
        .o_ev_ready  (ev_ready),
        .i_ev_mask   (ev_mask),
        .i_ev_press  (ev_press),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the multi-key debouncer
// Scans are sent through the valid/stall input channel and every event item
// is checked, field by field and in order, against a prediction made from
// the scan stream and the current register values. A directed opening covers
// full-width presses and releases, bounces and tick wrap. Random phases
// under several register settings and idling patterns follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import mkde_pkg::*;
();

    class key_event_scoreboard;
        t_phase          key_state [KEY_COUNT_DEF];
        logic [31:0]     press_tick [KEY_COUNT_DEF];
        logic            down_level;
        logic [15:0]     debounce_limit;
        t_key_event      expected_events [$];
        int              errors;
        int              scans_seen;
        int              events_seen;

        function new();
            foreach (key_state[k]) begin
                key_state[k]  = PH_IDLE;
                press_tick[k] = '0;
            end
            down_level     = DOWN_LEVEL_RESET;
            debounce_limit = DEBOUNCE_RESET;
            errors         = 0;
            scans_seen     = 0;
            events_seen    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DOWN_LEVEL: begin
                    down_level = data[0];
                end
                CFG_DEBOUNCE: begin
                    debounce_limit = data[DEBOUNCE_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_scan(t_scan_item scan);
            t_key_event  ev;
            logic        is_down;
            logic [31:0] elapsed;
            int          found;
            found = 0;
            scans_seen++;
            for (int k = 0; k < KEY_COUNT_DEF; k++) begin
                is_down         = (scan.key_levels[k] == down_level);
                ev.key_index    = KEY_IDX_W'(k);
                ev.last_of_scan = 1'b0;
                case (key_state[k])
                    PH_IDLE: begin
                        if (is_down) begin
                            press_tick[k] = scan.now_tick;
                            key_state[k]  = PH_DEBOUNCE;
                        end
                    end
                    PH_DEBOUNCE: begin
                        if (is_down) begin
                            elapsed = scan.now_tick - press_tick[k];
                            if (elapsed > {16'b0, debounce_limit}) begin
                                key_state[k] = PH_DOWN;
                                ev.pressed   = 1'b1;
                                expected_events.push_back(ev);
                                found++;
                            end
                        end else begin
                            key_state[k] = PH_IDLE;
                        end
                    end
                    default: begin
                        if (!is_down) begin
                            key_state[k] = PH_IDLE;
                            ev.pressed   = 1'b0;
                            expected_events.push_back(ev);
                            found++;
                        end
                    end
                endcase
            end
            if (found > 0) begin
                expected_events[expected_events.size()-1].last_of_scan = 1'b1;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_event(t_key_event got);
            t_key_event want;
            events_seen++;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event key %0d pressed %0b last %0b",
                                 got.key_index, got.pressed, got.last_of_scan));
                return;
            end
            want = expected_events.pop_front();
            if (got.key_index !== want.key_index) begin
                report($sformatf("key_index %0d, expected %0d",
                                 got.key_index, want.key_index));
            end
            if (got.pressed !== want.pressed) begin
                report($sformatf("pressed %0b on key %0d, expected %0b",
                                 got.pressed, want.key_index, want.pressed));
            end
            if (got.last_of_scan !== want.last_of_scan) begin
                report($sformatf("last_of_scan %0b on key %0d, expected %0b",
                                 got.last_of_scan, want.key_index, want.last_of_scan));
            end
        endtask
    endclass

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 45;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_scan_item            i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_key_event            o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    key_event_scoreboard sb;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  idle_cycles    = 0;
    int                  cfg_writes     = 0;

    multi_key_debounce_events dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_event(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    task send_scan(t_scan_item scan);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= scan;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_scan(scan);
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.expected_events.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
        cfg_writes++;
    endtask

    initial begin
        t_scan_item            scan;
        logic [KEY_COUNT_DEF-1:0] held_keys;
        logic [31:0]           world_tick;
        logic [31:0]           step;
        logic                  cur_down;
        logic [15:0]           cur_debounce;
        logic [CFG_DATA_W-1:0] data;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a key reads as down at level 0, limit of 20 ticks.
        send_scan({10'h3FF, 32'h0000_0000});
        send_scan({10'h000, 32'h0000_0064});
        send_scan({10'h000, 32'h0000_0078});
        send_scan({10'h000, 32'h0000_0079});
        send_scan({10'h3FF, 32'h0000_0082});
        send_scan({10'h2AA, 32'hFFFF_FFF0});
        send_scan({10'h3FF, 32'hFFFF_FFF5});
        send_scan({10'h155, 32'hFFFF_FFF8});
        send_scan({10'h155, 32'h0000_0010});
        send_scan({10'h154, 32'h0000_0011});
        send_scan({10'h3FF, 32'hFFFF_FFFF});
        send_scan({10'h3FE, 32'h7FFF_FFFF});
        send_scan({10'h3FE, 32'h8000_0000});
        send_scan({10'h3FE, 32'h8000_0014});
        send_scan({10'h3FF, 32'h0000_0000});

        held_keys  = '0;
        world_tick = $urandom;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            cur_down = p[0] ? 1'b0 : 1'b1;
            case (p)
                0: cur_debounce = 16'd0;
                1: cur_debounce = 16'hFFFF;
                2: cur_debounce = 16'd20;
                3: cur_debounce = 16'($urandom_range(300, 2));
                4: cur_debounce = 16'hFFFF;
                5: cur_debounce = 16'd1;
                6: cur_debounce = 16'd0;
                default: cur_debounce = 16'($urandom_range(40, 2));
            endcase
            if (p == 0) begin
                write_reg(CFG_SPARE_A, 16'($urandom));
                write_reg(CFG_SPARE_B, 16'($urandom));
            end
            data = 16'($urandom);
            data[0] = cur_down;
            write_reg(CFG_DOWN_LEVEL, data);
            write_reg(CFG_DEBOUNCE, cur_debounce);
            i_cfg_valid <= 1'b0;

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (p % 3 == 1) begin
                world_tick = 32'hFFFF_FFFF - 32'($urandom_range(3 * cur_debounce + 50));
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 10) begin
                    scan.key_levels = 10'($urandom);
                    scan.now_tick   = $urandom;
                    world_tick      = scan.now_tick;
                end else begin
                    case ($urandom_range(5))
                        0: step = '0;
                        1: step = {16'b0, cur_debounce};
                        2: step = {16'b0, cur_debounce} + 32'd1;
                        5: step = 32'($urandom_range(3));
                        default: step = 32'($urandom_range(2 * cur_debounce + 2));
                    endcase
                    world_tick = world_tick + step;
                    for (int k = 0; k < KEY_COUNT_DEF; k++) begin
                        if ($urandom_range(99) < 15) begin
                            held_keys[k] = ~held_keys[k];
                        end
                    end
                    scan.key_levels = cur_down ? held_keys : ~held_keys;
                    if ($urandom_range(99) < 8) begin
                        scan.key_levels[$urandom_range(KEY_COUNT_DEF - 1)] ^= 1'b1;
                    end
                    scan.now_tick = world_tick;
                end
                send_scan(scan);
                if (p == 2 && n == 20) begin
                    drain();
                end
            end
        end
        drain();

        $display("covered %0d scans, %0d events and %0d register writes",
                 sb.scans_seen, sb.events_seen, cfg_writes);
        $display("both down levels, limits from 0 to 65535, tick wrap, four idling patterns");
        if (sb.errors == 0 && sb.expected_events.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- multi_key_debounce_events.f -----
rtl/mkde_pkg.sv
rtl/mkde_scan.sv
rtl/mkde_emit.sv
rtl/multi_key_debounce_events.sv
sim/tb.sv
